@@ src/aes_pkg.sv @@
// AES-128 package: S-box tables, GF(2^8) helpers and round functions.
// Used by the key expansion unit and the cipher top level.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumWords  = 44;
  localparam int unsigned KeyW      = 64;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  typedef logic [127:0] state_t;

  // Multiply by x in GF(2^8), reducing by the AES polynomial
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    gmul = acc;
  endfunction

  // Forward S-box as a constant table
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse S-box
  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constants for words 4, 8 .. 40
  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of the state sits at bits 127-8i
  function automatic logic [7:0] get_byte(input state_t s, input int i);
    get_byte = s[127-8*i -: 8];
  endfunction

  function automatic state_t sub_bytes(input state_t s, input logic inv);
    state_t r;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    sub_bytes = r;
  endfunction

  function automatic state_t shift_rows(input state_t s, input logic inv);
    state_t r;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        if (inv) r[127-8*(4*((c+rw)%4)+rw) -: 8] = get_byte(s, 4*c+rw);
        else     r[127-8*(4*c+rw) -: 8] = get_byte(s, 4*((c+rw)%4)+rw);
      end
    end
    shift_rows = r;
  endfunction

  function automatic state_t mix_columns(input state_t s, input logic inv);
    state_t r;
    logic [7:0] a [4];
    logic [7:0] v;
    logic [7:0] coef [4];
    if (inv) begin
      coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) a[j] = get_byte(s, 4*c+j);
      for (int rw = 0; rw < 4; rw++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v = v ^ gmul(coef[(j-rw+4)%4], a[j]);
        r[127-8*(4*c+rw) -: 8] = v;
      end
    end
    mix_columns = r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

@@ src/aes_key_exp.sv @@
// AES-128 key schedule: holds the two key registers and the 11 round keys.
// Depends on aes_pkg. Re-expands one round key per cycle, restarting on any key write.
module aes_key_exp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [aes_pkg::KeyW-1:0]  cfg_data_i,
  output logic [127:0]              rkey_o [aes_pkg::NumRounds+1],
  output logic                      busy_o
);
  import aes_pkg::*;

  logic [KeyW-1:0]  key_hi_q, key_lo_q;
  logic [127:0]     rk_q [NumRounds+1];
  logic [3:0]       step_q;
  logic             busy_q;
  logic [127:0]     prev;
  logic [127:0]     next_rk;
  logic [31:0]      t;

  // Derive the next round key from the previous one
  always_comb begin
    prev = rk_q[step_q - 4'd1];
    t = sub_word({prev[23:0], prev[31:24]}) ^ {RCON[step_q - 4'd1], 24'h0};
    next_rk[127:96] = prev[127:96] ^ t;
    next_rk[95:64]  = prev[95:64] ^ next_rk[127:96];
    next_rk[63:32]  = prev[63:32] ^ next_rk[95:64];
    next_rk[31:0]   = prev[31:0] ^ next_rk[63:32];
  end

  // Key registers and sequenced expansion; reset starts an all-zero expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      step_q   <= 4'd1;
      busy_q   <= 1'b1;
      for (int i = 0; i <= NumRounds; i++) rk_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgKeyHigh: begin
          key_hi_q <= cfg_data_i;
          rk_q[0]  <= {cfg_data_i, key_lo_q};
        end
        CfgKeyLow: begin
          key_lo_q <= cfg_data_i;
          rk_q[0]  <= {key_hi_q, cfg_data_i};
        end
        default: ;
      endcase
      step_q <= 4'd1;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      rk_q[step_q] <= next_rk;
      step_q       <= step_q + 4'd1;
      if (step_q == 4'(NumRounds)) busy_q <= 1'b0;
    end
  end

  assign rkey_o = rk_q;
  assign busy_o = busy_q;
endmodule

@@ src/aes128_block_cipher.sv @@
// AES-128 ECB cipher, encrypt or decrypt per word, fully unrolled pipeline.
// 11 register stages: initial key add plus 10 rounds; the last stage drives
// the output.
// Throughput: one block per cycle; a stall freezes all stages.
// Reset clears valid bits and keys and expands the zero key; key writes
// re-expand the round keys; input ready stays low meanwhile.
module aes128_block_cipher (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [aes_pkg::KeyW-1:0]  cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [127:0]              s_axis_tdata,   // block_high, block_low
  input  logic                      s_axis_tuser,   // kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [127:0]              m_axis_tdata    // out_high, out_low
);
  import aes_pkg::*;

  localparam int unsigned NStg = NumRounds + 1;

  logic [127:0] rkey [NumRounds+1];
  logic         key_busy;
  state_t       st_q  [NStg];
  logic         dec_q [NStg];
  logic         vld_q [NStg];
  state_t       st_d  [NStg];
  state_t       in_st;
  logic         adv;

  aes_key_exp u_key (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .rkey_o(rkey),
    .busy_o(key_busy)
  );

  // Pipe moves when the last stage is empty or drained; hold input during expansion
  assign adv = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = adv && !key_busy;
  assign in_st = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  // Stage 0 is the initial key add; stages 1..10 are the rounds
  always_comb begin
    st_d[0] = in_st ^ (s_axis_tuser ? rkey[NumRounds] : rkey[0]);
    for (int r = 1; r < NStg; r++) begin
      if (!dec_q[r-1]) begin
        st_d[r] = shift_rows(sub_bytes(st_q[r-1], 1'b0), 1'b0);
        if (r != NumRounds) st_d[r] = mix_columns(st_d[r], 1'b0);
        st_d[r] = st_d[r] ^ rkey[r];
      end else begin
        st_d[r] = sub_bytes(shift_rows(st_q[r-1], 1'b1), 1'b1) ^ rkey[NumRounds-r];
        if (r != NumRounds) st_d[r] = mix_columns(st_d[r], 1'b1);
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NStg; r++) vld_q[r] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid && !key_busy;
      for (int r = 1; r < NStg; r++) vld_q[r] <= vld_q[r-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0]  <= st_d[0];
      dec_q[0] <= s_axis_tuser;
      for (int r = 1; r < NStg; r++) begin
        st_q[r]  <= st_d[r];
        dec_q[r] <= dec_q[r-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = {st_q[NStg-1][63:0], st_q[NStg-1][127:64]};

  // Held output stays put under backpressure
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  // Input ready follows output drain once the keys are ready
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !key_busy |-> s_axis_tready)
    else $error("pipe stalled with empty tail");
  // Accepted word reaches stage 0
  a_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word lost");
endmodule
